@@ src/connection_id_pool_manager_unit_assert.svh @@
// assertion macros for the connection id pool manager
// used by the sequencer and top level
`ifndef CONNECTION_ID_POOL_MANAGER_UNIT_ASSERT_SVH
`define CONNECTION_ID_POOL_MANAGER_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define CIDP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define CIDP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/cidp_pkg.sv @@
// shared types and constants of the connection id pool manager
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package cidp_pkg;
    localparam int PoolSize = 8;
    localparam int IdxW = $clog2(PoolSize);
    localparam int CntW = $clog2(PoolSize + 1);
    localparam int SeqW = 62;
    localparam int LenW = 5;
    localparam logic [LenW-1:0] MaxIdBytes = 5'd20;
    // seq, len, id words, token words
    localparam int EntW = SeqW + LenW + 64 + 64 + 32 + 64 + 64;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_USE = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_DUP = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_NONE = 2'd3;

    typedef struct packed {
        logic [SeqW-1:0] seq;
        logic [LenW-1:0] len;
        logic [63:0] w_low;
        logic [63:0] w_mid;
        logic [31:0] w_high;
        logic [63:0] t_low;
        logic [63:0] t_high;
    } entry_t;
endpackage
`default_nettype wire

@@ src/cidp_ram.sv @@
// generic single-port-write, single-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module cidp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ src/connection_id_pool_manager_unit.sv @@
// top level of the connection id pool manager: command sequencer and entry memory
// depends on cidp_pkg, cidp_ram and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
// One request at a time. The pool's entry payloads (sequence number, length, id and
// token) live in one 8-deep ram with a registered read; in-use and retired marks are
// small flag registers. Each request walks the live entries once through the ram read
// port, one entry per cycle; an add writes its entry in the decide state and needs no
// state of its own. The result is held in an output register until taken; ready is
// low while a request is in work or a result waits.
module connection_id_pool_manager_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [61:0] seq_num,
    input  wire logic [61:0] retire_below,
    input  wire logic [4:0]  id_length,
    input  wire logic [63:0] id_word_low,
    input  wire logic [63:0] id_word_mid,
    input  wire logic [31:0] id_word_high,
    input  wire logic [63:0] token_low,
    input  wire logic [63:0] token_high,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [2:0]       slot_index,
    output logic [61:0]      found_seq,
    output logic [4:0]       found_length,
    output logic [63:0]      found_word_low,
    output logic [63:0]      found_word_mid,
    output logic [31:0]      found_word_high,
    output logic [63:0]      found_token_low,
    output logic [63:0]      found_token_high,
    output logic             retire_request,
    output logic [61:0]      retire_number
);
`include "connection_id_pool_manager_unit_assert.svh"

    localparam int N = cidp_pkg::PoolSize;
    localparam int IW = cidp_pkg::IdxW;
    localparam int CW = cidp_pkg::CntW;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_DECIDE, S_OUT} state_t;

    state_t state_reg;
    logic [CW-1:0] count_reg;
    logic [N-1:0] in_use_reg, retired_reg;
    // request fields latched at accept
    logic [1:0] cmd_reg;
    logic [61:0] rpt_reg;
    cidp_pkg::entry_t req_reg;
    // scan address and the index of the entry whose read data is now valid
    logic [CW-1:0] raddr_reg;
    logic [IW-1:0] ridx_reg;
    // scan results
    logic dup_reg, match_reg, free_reg, old_reg;
    logic [IW-1:0] dup_idx_reg, match_idx_reg, free_idx_reg;
    logic [61:0] old_seq_reg;
    // output register
    logic [1:0] status_reg;
    logic [2:0] slot_reg;
    cidp_pkg::entry_t found_reg;
    logic retire_reg;
    logic [61:0] retire_num_reg;

    logic ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    cidp_pkg::entry_t ram_wdata, ram_rdata;

    cidp_ram #(.WIDTH(cidp_pkg::EntW), .DEPTH(N)) u_entries (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign ram_raddr = raddr_reg[IW-1:0];
    assign ram_wdata = req_reg;

    // store decision: append while room, else first retired and not in use
    logic can_store;
    logic [IW-1:0] store_idx;
    always_comb
    begin
        can_store = 1'b0;
        store_idx = '0;
        if (count_reg < CW'(N))
        begin
            can_store = 1'b1;
            store_idx = count_reg[IW-1:0];
        end
        else if (free_reg)
        begin
            can_store = 1'b1;
            store_idx = free_idx_reg;
        end
    end
    assign ram_we = (state_reg == S_DECIDE) && (cmd_reg == cidp_pkg::CMD_ADD) &&
                    !dup_reg && can_store;
    assign ram_waddr = store_idx;

    // per-entry evaluation of the read data; retire mark applies before other checks
    // an entry already retired keeps its in-use mark
    logic rd_retired_now, rd_in_use_now;
    always_comb
    begin
        rd_retired_now = retired_reg[ridx_reg];
        rd_in_use_now = in_use_reg[ridx_reg];
        if (cmd_reg == cidp_pkg::CMD_ADD && ram_rdata.seq < rpt_reg &&
            !retired_reg[ridx_reg])
        begin
            rd_retired_now = 1'b1;
            rd_in_use_now = 1'b0;
        end
    end

    // result of the request, taken into the output register in the decide cycle
    logic [1:0] dec_status;
    logic [2:0] dec_slot;
    logic dec_retire;
    logic [61:0] dec_retire_num;
    always_comb
    begin
        dec_status = cidp_pkg::ST_NONE;
        dec_slot = '0;
        dec_retire = 1'b0;
        dec_retire_num = '0;
        case (cmd_reg)
            cidp_pkg::CMD_ADD:
            begin
                if (dup_reg)
                begin
                    dec_status = cidp_pkg::ST_DUP;
                    dec_slot = 3'(dup_idx_reg);
                end
                else if (can_store)
                begin
                    dec_status = cidp_pkg::ST_DONE;
                    dec_slot = 3'(store_idx);
                end
                else
                begin
                    dec_status = cidp_pkg::ST_FULL;
                end
            end
            cidp_pkg::CMD_USE:
            begin
                dec_retire = old_reg;
                dec_retire_num = old_reg ? old_seq_reg : '0;
                if (match_reg)
                begin
                    dec_status = cidp_pkg::ST_DONE;
                    dec_slot = 3'(match_idx_reg);
                end
            end
            cidp_pkg::CMD_QUERY:
            begin
                if (free_reg)
                begin
                    dec_status = cidp_pkg::ST_DONE;
                    dec_slot = 3'(free_idx_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status = status_reg;
    assign slot_index = slot_reg;
    assign found_seq = found_reg.seq;
    assign found_length = found_reg.len;
    assign found_word_low = found_reg.w_low;
    assign found_word_mid = found_reg.w_mid;
    assign found_word_high = found_reg.w_high;
    assign found_token_low = found_reg.t_low;
    assign found_token_high = found_reg.t_high;
    assign retire_request = retire_reg;
    assign retire_number = retire_num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            in_use_reg <= '0;
            retired_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg <= cmd;
                        rpt_reg <= retire_below;
                        req_reg.seq <= seq_num;
                        req_reg.len <= (id_length > cidp_pkg::MaxIdBytes) ?
                                       cidp_pkg::MaxIdBytes : id_length;
                        req_reg.w_low <= id_word_low;
                        req_reg.w_mid <= id_word_mid;
                        req_reg.w_high <= id_word_high;
                        req_reg.t_low <= token_low;
                        req_reg.t_high <= token_high;
                        raddr_reg <= '0;
                        dup_reg <= 1'b0;
                        match_reg <= 1'b0;
                        free_reg <= 1'b0;
                        old_reg <= 1'b0;
                        dup_idx_reg <= '0;
                        match_idx_reg <= '0;
                        free_idx_reg <= '0;
                        old_seq_reg <= '0;
                        found_reg <= '0;
                        state_reg <= (count_reg == '0) ? S_DECIDE : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // issue read of raddr; the previous read is evaluated below
                    ridx_reg <= raddr_reg[IW-1:0];
                    raddr_reg <= raddr_reg + CW'(1);
                    if (raddr_reg + CW'(1) == count_reg)
                    begin
                        state_reg <= S_LAST;
                    end
                end
                S_LAST:
                begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    status_reg <= dec_status;
                    slot_reg <= dec_slot;
                    retire_reg <= dec_retire;
                    retire_num_reg <= dec_retire_num;
                    if (ram_we)
                    begin
                        in_use_reg[store_idx] <= 1'b0;
                        retired_reg[store_idx] <= 1'b0;
                        if (count_reg < CW'(N))
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                    end
                    else if (cmd_reg == cidp_pkg::CMD_USE && match_reg)
                    begin
                        in_use_reg[match_idx_reg] <= 1'b1;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // evaluation of the read data, in the cycle after each read was issued
            if ((state_reg == S_SCAN && raddr_reg != '0) || state_reg == S_LAST)
            begin
                case (cmd_reg)
                    cidp_pkg::CMD_ADD:
                    begin
                        retired_reg[ridx_reg] <= rd_retired_now;
                        in_use_reg[ridx_reg] <= rd_in_use_now;
                        if (!dup_reg && ram_rdata.seq == req_reg.seq)
                        begin
                            dup_reg <= 1'b1;
                            dup_idx_reg <= ridx_reg;
                        end
                        if (!free_reg && rd_retired_now && !rd_in_use_now)
                        begin
                            free_reg <= 1'b1;
                            free_idx_reg <= ridx_reg;
                        end
                    end
                    cidp_pkg::CMD_USE:
                    begin
                        if (in_use_reg[ridx_reg])
                        begin
                            in_use_reg[ridx_reg] <= 1'b0;
                            old_reg <= 1'b1;
                            old_seq_reg <= ram_rdata.seq;
                        end
                        if (!match_reg && ram_rdata.seq == req_reg.seq)
                        begin
                            match_reg <= 1'b1;
                            match_idx_reg <= ridx_reg;
                        end
                    end
                    cidp_pkg::CMD_QUERY:
                    begin
                        if (!free_reg && !in_use_reg[ridx_reg] && !retired_reg[ridx_reg])
                        begin
                            free_reg <= 1'b1;
                            free_idx_reg <= ridx_reg;
                            found_reg <= ram_rdata;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    `CIDP_ASSERT_IMP(a_ready_idle, in_ready, !out_valid, "ready while result pending")
    `CIDP_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CW'(N), "entry count overflow")
    `CIDP_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready,
        "second request taken while busy")
    `CIDP_ASSERT_IMP(a_write_add, ram_we, cmd_reg == cidp_pkg::CMD_ADD,
        "entry write outside add")
endmodule
`default_nettype wire
